// ===== sv/sbs_pkg.sv =====
`timescale 1ns / 1ps
package sbs_pkg;

  localparam int MAX_RECORDS_DEF = 64;

  localparam int PAYLOAD_W = 64 + 64 + 16 + 16 + 32 + 32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_EMIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_TEXTURE     = 2'd0,
    MODE_LAYER       = 2'd1,
    MODE_LAYER_TEX   = 2'd2,
    MODE_SPARE       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FETCH = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  localparam logic [7:0] ALPHA_ZERO = 8'h00;

  function automatic logic [31:0] sort_key(input logic [1:0] mode, input logic [15:0] tex,
                                           input logic [15:0] layer);
    logic [31:0] k;
    unique case (mode)
      MODE_LAYER:     k = {16'h0000, layer};
      MODE_LAYER_TEX: k = {layer, tex};
      default:        k = {16'h0000, tex};
    endcase
    return k;
  endfunction

endpackage

// ===== sv/sprite_batch_stable_sorter.sv =====
`timescale 1ns / 1ps
// Sprite batch stable sorter.
// Input channel (in_valid / in_stall) carries one command word: clear, add a
// record, or emit. Adds with zero alpha are dropped; adds to a full store are
// dropped and set the sticky overflowed flag, which clear resets.
// Emit sends every stored record as one output word each (out_valid /
// out_stall), in stable ascending order of the key picked by sort_mode
// (config channel cfg_valid / cfg_ready, always ready), last_record on the
// final word. An empty store emits nothing.
// Emit: each output word needs a full scan of the key memory (one read a
// cycle) for the smallest (key, index) above the previous one, then one
// payload read. in_stall is high for the whole emit run. A stalled output
// word holds.
// Reset (rst, synchronous) empties the store, clears the flag and sets
// sort_mode to texture order. Store contents need no clearing.
module sprite_batch_stable_sorter #(
  parameter int MAX_RECORDS = sbs_pkg::MAX_RECORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  sort_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] dest_rect,
  input  logic [63:0] clip_rect,
  input  logic [15:0] texture_id,
  input  logic [15:0] layer_id,
  input  logic [31:0] color_rgba,
  input  logic [31:0] angle_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_dest_rect,
  output logic [63:0] out_clip_rect,
  output logic [15:0] out_texture_id,
  output logic [15:0] out_layer_id,
  output logic [31:0] out_color_rgba,
  output logic [31:0] out_angle_bits,
  output logic        last_record,
  output logic        overflowed
);

  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_RECORDS);

  sbs_pkg::state_t state, state_next;
  logic [1:0]    mode;
  logic [CW-1:0] count;
  logic          ovf;
  logic [IW-1:0] scan_idx;     // next key address to read
  logic          issue_done;   // all keys of this scan requested
  logic          rd_valid;     // key_q holds entry rd_idx
  logic [IW-1:0] rd_idx;
  logic          have_best;
  logic [31:0]   best_key;
  logic [IW-1:0] best_idx;
  logic          have_prev;    // an earlier word of this run was sent
  logic [31:0]   prev_key;
  logic [IW-1:0] prev_idx;
  logic [IW-1:0] pos;          // output position within the run

  logic [IW-1:0] last_idx;
  logic          accept, wr_en, key_rd_en, pay_rd_en;
  logic [31:0]   key_q, cand_key;
  logic [sbs_pkg::PAYLOAD_W-1:0] pay_q;
  logic          above_prev, below_best;

  assign last_idx  = IW'(count - CW'(1));
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != sbs_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign wr_en     = accept && (operation == sbs_pkg::OP_ADD) &&
                     (color_rgba[7:0] != sbs_pkg::ALPHA_ZERO) && (count < FULL);
  assign key_rd_en = (state == sbs_pkg::ST_SCAN) && !issue_done;
  assign pay_rd_en = (state == sbs_pkg::ST_FETCH);

  sbs_store #(.MAX_RECORDS(MAX_RECORDS)) u_store (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (IW'(count)),
    .wr_key      ({layer_id, texture_id}),
    .wr_payload  ({dest_rect, clip_rect, texture_id, layer_id, color_rgba, angle_bits}),
    .key_rd_en   (key_rd_en),
    .key_rd_addr (scan_idx),
    .key_q       (key_q),
    .pay_rd_en   (pay_rd_en),
    .pay_rd_addr (best_idx),
    .pay_q       (pay_q)
  );

  // Key applies the current mode; key memory keeps raw layer and texture
  assign cand_key   = sbs_pkg::sort_key(mode, key_q[15:0], key_q[31:16]);
  assign above_prev = !have_prev || (cand_key > prev_key) ||
                      ((cand_key == prev_key) && (rd_idx > prev_idx));
  // strict compare keeps the earliest index among equal keys
  assign below_best = !have_best || (cand_key < best_key);

  always_comb begin
    state_next = state;
    unique case (state)
      sbs_pkg::ST_IDLE: begin
        if (accept && (operation == sbs_pkg::OP_EMIT) && (count != '0)) begin
          state_next = sbs_pkg::ST_SCAN;
        end
      end
      sbs_pkg::ST_SCAN: begin
        if (rd_valid && (rd_idx == last_idx)) begin
          state_next = sbs_pkg::ST_FETCH;
        end
      end
      sbs_pkg::ST_FETCH: begin
        state_next = sbs_pkg::ST_OUT;
      end
      sbs_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = (pos == last_idx) ? sbs_pkg::ST_IDLE : sbs_pkg::ST_SCAN;
        end
      end
      default: state_next = sbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= sbs_pkg::MODE_TEXTURE;
      count      <= '0;
      ovf        <= 1'b0;
      scan_idx   <= '0;
      issue_done <= 1'b0;
      rd_valid   <= 1'b0;
      rd_idx     <= '0;
      have_best  <= 1'b0;
      have_prev  <= 1'b0;
      pos        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= sort_mode;
      end
      if (accept) begin
        case (operation)
          sbs_pkg::OP_CLEAR: begin
            count <= '0;
            ovf   <= 1'b0;
          end
          sbs_pkg::OP_ADD: begin
            if (color_rgba[7:0] != sbs_pkg::ALPHA_ZERO) begin
              if (count < FULL) begin
                count <= count + CW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end
          end
          sbs_pkg::OP_EMIT: begin
            have_prev  <= 1'b0;
            pos        <= '0;
            scan_idx   <= '0;
            issue_done <= 1'b0;
            have_best  <= 1'b0;
          end
          default: ;
        endcase
      end
      rd_valid <= key_rd_en;
      if (key_rd_en) begin
        rd_idx <= scan_idx;
        if (scan_idx == last_idx) begin
          issue_done <= 1'b1;
        end else begin
          scan_idx <= scan_idx + IW'(1);
        end
      end
      if (rd_valid && above_prev && below_best) begin
        have_best <= 1'b1;
        best_key  <= cand_key;
        best_idx  <= rd_idx;
      end
      if (state == sbs_pkg::ST_OUT && !out_stall) begin
        have_prev  <= 1'b1;
        prev_key   <= best_key;
        prev_idx   <= best_idx;
        pos        <= pos + IW'(1);
        scan_idx   <= '0;
        issue_done <= 1'b0;
        have_best  <= 1'b0;
      end
    end
  end

  assign out_valid      = (state == sbs_pkg::ST_OUT);
  assign out_dest_rect  = pay_q[223:160];
  assign out_clip_rect  = pay_q[159:96];
  assign out_texture_id = pay_q[95:80];
  assign out_layer_id   = pay_q[79:64];
  assign out_color_rgba = pay_q[63:32];
  assign out_angle_bits = pay_q[31:0];
  assign last_record    = (pos == last_idx);
  assign overflowed     = ovf;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("record count above capacity");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_record) |=> !out_valid && !in_stall)
    else $error("run did not end after last record");
  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0) && have_best)
    else $error("output word without a selected record");
  a_rd_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state) == sbs_pkg::ST_SCAN)
    else $error("key read outside scan");

endmodule

// ===== sv/sbs_store.sv =====
`timescale 1ns / 1ps
// Two synchronous memories: sort keys (layer, texture) and full record payload.
module sbs_store #(
  parameter int MAX_RECORDS = sbs_pkg::MAX_RECORDS_DEF,
  localparam int IW = $clog2(MAX_RECORDS)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IW-1:0]                wr_addr,
  input  logic [31:0]                  wr_key,
  input  logic [sbs_pkg::PAYLOAD_W-1:0] wr_payload,
  input  logic                         key_rd_en,
  input  logic [IW-1:0]                key_rd_addr,
  output logic [31:0]                  key_q,
  input  logic                         pay_rd_en,
  input  logic [IW-1:0]                pay_rd_addr,
  output logic [sbs_pkg::PAYLOAD_W-1:0] pay_q
);

  logic [31:0]                  key_mem [MAX_RECORDS];
  logic [sbs_pkg::PAYLOAD_W-1:0] pay_mem [MAX_RECORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (key_rd_en) begin
      key_q <= key_mem[key_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pay_mem[wr_addr] <= wr_payload;
    end
    if (pay_rd_en) begin
      pay_q <= pay_mem[pay_rd_addr];
    end
  end

endmodule

// ===== tb/tb_sprite_batch_stable_sorter.sv =====
`timescale 1ns / 1ps
module tb_sprite_batch_stable_sorter;

  localparam int DEPTH = sbs_pkg::MAX_RECORDS_DEF;
  localparam int CYCLE_LIMIT = 1500000;

  // Sprite record as stored by the block.
  typedef struct packed {
    logic [63:0] dest;
    logic [63:0] clip;
    logic [15:0] tex;
    logic [15:0] layer;
    logic [31:0] color;
    logic [31:0] angle;
  } sprite_t;

  // Word seen on the output side.
  typedef struct packed {
    sprite_t     rec;
    logic        last;
    logic        ovf;
  } emitted_t;

  // One row of the directed table.
  typedef struct packed {
    sbs_pkg::op_t op;
    sprite_t      rec;
  } cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  sort_mode = sbs_pkg::MODE_TEXTURE;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = sbs_pkg::OP_NONE;
  logic [63:0] dest_rect = '0;
  logic [63:0] clip_rect = '0;
  logic [15:0] texture_id = '0;
  logic [15:0] layer_id = '0;
  logic [31:0] color_rgba = '0;
  logic [31:0] angle_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_dest_rect;
  logic [63:0] out_clip_rect;
  logic [15:0] out_texture_id;
  logic [15:0] out_layer_id;
  logic [31:0] out_color_rgba;
  logic [31:0] out_angle_bits;
  logic        last_record;
  logic        overflowed;

  sprite_batch_stable_sorter i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .sort_mode      (sort_mode),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .dest_rect      (dest_rect),
    .clip_rect      (clip_rect),
    .texture_id     (texture_id),
    .layer_id       (layer_id),
    .color_rgba     (color_rgba),
    .angle_bits     (angle_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dest_rect  (out_dest_rect),
    .out_clip_rect  (out_clip_rect),
    .out_texture_id (out_texture_id),
    .out_layer_id   (out_layer_id),
    .out_color_rgba (out_color_rgba),
    .out_angle_bits (out_angle_bits),
    .last_record    (last_record),
    .overflowed     (overflowed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the block: store, count, sticky flag and the sort mode.
  sprite_t    mirror_store[DEPTH];
  int         mirror_count = 0;
  logic       mirror_ovf = 1'b0;
  logic [1:0] mirror_mode = sbs_pkg::MODE_TEXTURE;

  emitted_t   pending_words[$];
  int         errors = 0;
  int         words_seen = 0;
  int         emits_sent = 0;
  int         cycles = 0;
  bit         gaps_on = 1'b1;   // random idling on both sides
  bit         hold_out = 1'b0;  // long receiver hold-off
  bit         overflow_seen = 1'b0;

  function automatic logic [31:0] order_key(sprite_t r, logic [1:0] mode);
    if (mode == sbs_pkg::MODE_LAYER) return {16'h0000, r.layer};
    if (mode == sbs_pkg::MODE_LAYER_TEX) return {r.layer, r.tex};
    return {16'h0000, r.tex};  // texture order, spare mode included
  endfunction

  // Apply one accepted command to the mirror; queue the words an emit gives.
  task automatic apply_command(cmd_t c);
    int idx[DEPTH];
    int j;
    int cur;
    emitted_t w;
    case (c.op)
      sbs_pkg::OP_CLEAR: begin
        mirror_count = 0;
        mirror_ovf = 1'b0;
      end
      sbs_pkg::OP_ADD: begin
        if (c.rec.color[7:0] != sbs_pkg::ALPHA_ZERO) begin
          if (mirror_count >= DEPTH) begin
            mirror_ovf = 1'b1;
            overflow_seen = 1'b1;
          end else begin
            mirror_store[mirror_count] = c.rec;
            mirror_count++;
          end
        end
      end
      sbs_pkg::OP_EMIT: begin
        for (int i = 0; i < mirror_count; i++) idx[i] = i;
        // stable insertion: pass only strictly larger keys
        for (int i = 1; i < mirror_count; i++) begin
          cur = idx[i];
          j = i;
          while (j > 0 && order_key(mirror_store[idx[j-1]], mirror_mode) >
                          order_key(mirror_store[cur], mirror_mode)) begin
            idx[j] = idx[j-1];
            j--;
          end
          idx[j] = cur;
        end
        for (int i = 0; i < mirror_count; i++) begin
          w.rec = mirror_store[idx[i]];
          w.last = (i == mirror_count - 1);
          w.ovf = mirror_ovf;
          pending_words.push_back(w);
        end
      end
      default: ;
    endcase
  endtask

  // Drive one command word and hold it until accepted. Valid stays high
  // afterwards so the next word can follow at once; callers drop it before
  // waiting on anything else.
  task automatic send_command(cmd_t c);
    if (gaps_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 33);
    end
    in_valid   <= 1'b1;
    operation  <= c.op;
    dest_rect  <= c.rec.dest;
    clip_rect  <= c.rec.clip;
    texture_id <= c.rec.tex;
    layer_id   <= c.rec.layer;
    color_rgba <= c.rec.color;
    angle_bits <= c.rec.angle;
    do @(posedge clk); while (in_stall);
    apply_command(c);
    if (c.op == sbs_pkg::OP_EMIT) emits_sent++;
    @(negedge clk);
  endtask

  // Register writes only with nothing outstanding plus a drain margin.
  task automatic write_mode(logic [1:0] m);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid <= 1'b1;
    sort_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    mirror_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_t random_add(int key_span);
    cmd_t c;
    c.op = sbs_pkg::OP_ADD;
    c.rec.dest  = {$urandom, $urandom};
    c.rec.clip  = {$urandom, $urandom};
    // narrow key span forces ties to exercise stability
    c.rec.tex   = (key_span == 0) ? 16'($urandom) : 16'($urandom_range(key_span));
    c.rec.layer = (key_span == 0) ? 16'($urandom) : 16'($urandom_range(key_span));
    c.rec.color = $urandom;
    if ($urandom_range(9) == 0) c.rec.color[7:0] = sbs_pkg::ALPHA_ZERO;
    else if (c.rec.color[7:0] == sbs_pkg::ALPHA_ZERO) c.rec.color[0] = 1'b1;
    c.rec.angle = $urandom;
    return c;
  endfunction

  // Output side: stall at random, long hold-off when requested.
  always @(negedge clk) begin
    if (hold_out) out_stall <= 1'b1;
    else if (gaps_on) out_stall <= ($urandom_range(99) < 33);
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    emitted_t exp_w;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected output word: texture %h layer %h", out_texture_id, out_layer_id);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        if (out_dest_rect !== exp_w.rec.dest) begin
          $error("out_dest_rect exp %h got %h", exp_w.rec.dest, out_dest_rect); errors++;
        end
        if (out_clip_rect !== exp_w.rec.clip) begin
          $error("out_clip_rect exp %h got %h", exp_w.rec.clip, out_clip_rect); errors++;
        end
        if (out_texture_id !== exp_w.rec.tex) begin
          $error("out_texture_id exp %h got %h", exp_w.rec.tex, out_texture_id); errors++;
        end
        if (out_layer_id !== exp_w.rec.layer) begin
          $error("out_layer_id exp %h got %h", exp_w.rec.layer, out_layer_id); errors++;
        end
        if (out_color_rgba !== exp_w.rec.color) begin
          $error("out_color_rgba exp %h got %h", exp_w.rec.color, out_color_rgba); errors++;
        end
        if (out_angle_bits !== exp_w.rec.angle) begin
          $error("out_angle_bits exp %h got %h", exp_w.rec.angle, out_angle_bits); errors++;
        end
        if (last_record !== exp_w.last) begin
          $error("last_record exp %b got %b", exp_w.last, last_record); errors++;
        end
        if (overflowed !== exp_w.ovf) begin
          $error("overflowed exp %b got %b", exp_w.ovf, overflowed); errors++;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Long receiver hold-off, counted here while commands keep coming.
  initial begin
    wait (emits_sent >= 6);
    @(negedge clk);
    hold_out = 1'b1;
    repeat (400) @(negedge clk);
    hold_out = 1'b0;
  end

  cmd_t directed[] = '{
    // emit on an empty store gives nothing
    '{sbs_pkg::OP_EMIT,  '{64'h0, 64'h0, 16'h0, 16'h0, 32'h0, 32'h0}},
    '{sbs_pkg::OP_ADD,   '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'hFFFF, 16'h0000,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{sbs_pkg::OP_ADD,   '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 16'hFFFF,
                           32'h0000_0001, 32'h0}},
    // zero alpha is dropped
    '{sbs_pkg::OP_ADD,   '{64'h1, 64'h2, 16'h0001, 16'h0001, 32'hFFFF_FF00, 32'h3}},
    // equal texture key keeps arrival order
    '{sbs_pkg::OP_ADD,   '{64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, 16'hFFFF,
                           16'h0001, 32'h1234_5680, 32'h3F80_0000}},
    '{sbs_pkg::OP_ADD,   '{64'h10, 64'h20, 16'h8000, 16'h8000, 32'h8000_00FF,
                           32'h8000_0000}},
    '{sbs_pkg::OP_EMIT,  '{64'h0, 64'h0, 16'h0, 16'h0, 32'h0, 32'h0}},
    // emit leaves the store, so a second emit repeats the run
    '{sbs_pkg::OP_EMIT,  '{64'h0, 64'h0, 16'h0, 16'h0, 32'h0, 32'h0}},
    // unused operation is ignored
    '{sbs_pkg::OP_NONE,  '{64'h7, 64'h7, 16'h7, 16'h7, 32'h7, 32'h7}},
    '{sbs_pkg::OP_CLEAR, '{64'h0, 64'h0, 16'h0, 16'h0, 32'h0, 32'h0}},
    '{sbs_pkg::OP_EMIT,  '{64'h0, 64'h0, 16'h0, 16'h0, 32'h0, 32'h0}}
  };

  // Known outcome of the first non-empty emit: four records survive.
  initial begin
    logic [1:0] modes[5];
    cmd_t c;
    int n;
    modes = '{sbs_pkg::MODE_TEXTURE, sbs_pkg::MODE_LAYER, sbs_pkg::MODE_LAYER_TEX,
              sbs_pkg::MODE_SPARE, sbs_pkg::MODE_LAYER_TEX};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      send_command(directed[i]);
      // five adds with one zero alpha leave four words to come
      if (i == 6 && pending_words.size() != 4) begin
        $error("pending words exp %0d got %0d", 4, pending_words.size()); errors++;
      end
    end

    // Overflow: fill past the store, check the sticky flag on emit.
    write_mode(sbs_pkg::MODE_LAYER);
    for (int i = 0; i < DEPTH + 2; i++) begin
      c = random_add(3);
      c.rec.color[7:0] = 8'h80;
      send_command(c);
    end
    c.op = sbs_pkg::OP_EMIT;
    send_command(c);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    c.op = sbs_pkg::OP_CLEAR;
    send_command(c);

    // Random phases: small batches per mode, one with no idling.
    foreach (modes[m]) begin
      write_mode(modes[m]);
      gaps_on = (m != 2);
      for (int b = 0; b < 2; b++) begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(19) == 0) begin
            c = random_add(0);
            c.op = sbs_pkg::op_t'($urandom_range(3));
          end else begin
            c = random_add($urandom_range(1) ? 4 : 0);
          end
          send_command(c);
        end
        c.op = sbs_pkg::OP_EMIT;
        send_command(c);
        if ($urandom_range(2) == 0) begin
          c.op = sbs_pkg::OP_CLEAR;
          send_command(c);
        end
      end
      c.op = sbs_pkg::OP_CLEAR;
      send_command(c);
    end
    gaps_on = 1'b1;
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Covered %0d emits and %0d output words over all sort modes,", emits_sent,
             words_seen);
    $display("ties, zero alpha, empty emit, overflow (%0b) and an output hold-off.",
             overflow_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sprite_batch_stable_sorter.f =====
sv/sbs_pkg.sv
sv/sbs_store.sv
sv/sprite_batch_stable_sorter.sv
tb/tb_sprite_batch_stable_sorter.sv
